@@ hw/rtl/kda_pkg.sv @@
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types and constants for the key debounce / auto-repeat block.
// ----------------------------------------------------------------------------
package kda_pkg;

	localparam int NUM_KEYS_DEF = 3;
	localparam int CNT_W        = 8;
	localparam int CFG_DATA_W   = 8;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_STEP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EN    = 2'd3;

	// register reset values
	localparam logic [CNT_W-1:0] DEBOUNCE_RST     = 8'd3;
	localparam logic [CNT_W-1:0] REPEAT_START_RST = 8'd50;
	localparam logic [CNT_W-1:0] REPEAT_STEP_RST  = 8'd10;
	localparam int               REPEAT_EN_RST    = 6;

	// settings every lane sees
	typedef struct packed {
		logic [CNT_W-1:0] debounce_ticks;
		logic [CNT_W-1:0] repeat_start_ticks;
		logic [CNT_W-1:0] repeat_reload;
	} kda_cfg_t;

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		inc_sat = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

endpackage

@@ hw/rtl/kda_lane.sv @@
// ----------------------------------------------------------------------------
// kda_lane
// Per-key debounce and hold counters; flags a press or repeat each tick.
// ----------------------------------------------------------------------------
module kda_lane
	import kda_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tick,
	input  logic     raw,
	input  logic     repeat_en,
	input  kda_cfg_t cfg,
	output logic     event_hit
);

	logic             stable_q;
	logic [CNT_W-1:0] db_cnt_q;
	logic [CNT_W-1:0] hold_cnt_q;

	logic             stable_n;
	logic [CNT_W-1:0] db_cnt_n;
	logic [CNT_W-1:0] hold_mid;
	logic [CNT_W-1:0] hold_cnt_n;
	logic [CNT_W-1:0] db_inc;
	logic [CNT_W-1:0] hold_inc;
	logic             press;
	logic             rep;

	always_comb begin
		db_inc   = inc_sat(db_cnt_q);
		stable_n = stable_q;
		db_cnt_n = '0;
		hold_mid = hold_cnt_q;
		press    = 1'b0;
		if (raw != stable_q) begin
			if (db_inc >= cfg.debounce_ticks) begin
				stable_n = raw;
				hold_mid = '0;
				press    = raw;
			end else begin
				db_cnt_n = db_inc;
			end
		end

		// hold counting uses the level after this tick's debounce decision
		hold_inc   = inc_sat(hold_mid);
		hold_cnt_n = hold_mid;
		rep        = 1'b0;
		if (repeat_en && stable_n) begin
			if (hold_inc >= cfg.repeat_start_ticks) begin
				rep        = 1'b1;
				hold_cnt_n = cfg.repeat_reload;
			end else begin
				hold_cnt_n = hold_inc;
			end
		end
	end

	assign event_hit = press | rep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= 1'b0;
			db_cnt_q   <= '0;
			hold_cnt_q <= '0;
		end else if (tick) begin
			stable_q   <= stable_n;
			db_cnt_q   <= db_cnt_n;
			hold_cnt_q <= hold_cnt_n;
		end
	end

endmodule

@@ hw/rtl/kda_merge.sv @@
// ----------------------------------------------------------------------------
// kda_merge
// Collects the lane event bits into one result and holds it in an output
// register backed by a one-entry skid buffer.
// ----------------------------------------------------------------------------
module kda_merge
	import kda_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic [NUM_KEYS-1:0] lane_events,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [NUM_KEYS-1:0] key_events
);

	logic                out_valid_q;
	logic                skid_valid_q;
	logic [NUM_KEYS-1:0] out_data_q;
	logic [NUM_KEYS-1:0] skid_data_q;
	logic                out_fire;

	assign out_fire   = out_valid_q && !out_stall;
	assign full       = skid_valid_q;
	assign out_valid  = out_valid_q;
	assign key_events = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (tick) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_data_q <= skid_data_q;
			end
		end else if (tick) begin
			if (!out_valid_q || out_fire) begin
				out_data_q <= lane_events;
			end else begin
				skid_data_q <= lane_events;
			end
		end
	end

endmodule

@@ hw/rtl/key_debounce_autorepeat.sv @@
// ----------------------------------------------------------------------------
// key_debounce_autorepeat
// Each accepted tick's event mask is registered in the output or skid buffer.
// Throughput: one tick per cycle unless stalled; every key has its own lane.
// Input stalls only while a result sits in the skid buffer.
// Reset: keys released, counters zero, registers at defaults (3, 50, 10, 6).
// ----------------------------------------------------------------------------
module key_debounce_autorepeat
	import kda_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [NUM_KEYS-1:0]   raw_pressed,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [NUM_KEYS-1:0]   key_events,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [CNT_W-1:0]    debounce_q;
	logic [CNT_W-1:0]    rep_start_q;
	logic [CNT_W-1:0]    rep_step_q;
	logic [NUM_KEYS-1:0] rep_en_q;

	kda_cfg_t            lane_cfg;
	logic                tick;
	logic                merge_full;
	logic [NUM_KEYS-1:0] lane_events;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			rep_start_q <= REPEAT_START_RST;
			rep_step_q  <= REPEAT_STEP_RST;
			rep_en_q    <= NUM_KEYS'(REPEAT_EN_RST);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DEBOUNCE:     debounce_q  <= cfg_wdata;
				REG_REPEAT_START: rep_start_q <= cfg_wdata;
				REG_REPEAT_STEP:  rep_step_q  <= cfg_wdata;
				REG_REPEAT_EN:    rep_en_q    <= cfg_wdata[NUM_KEYS-1:0];
				default: ;
			endcase
		end
	end

	// reload after a repeat, clamped at zero
	always_comb begin
		lane_cfg.debounce_ticks     = debounce_q;
		lane_cfg.repeat_start_ticks = rep_start_q;
		lane_cfg.repeat_reload      = (rep_start_q > rep_step_q) ?
		                              rep_start_q - rep_step_q : '0;
	end

	assign in_stall = merge_full;
	assign tick     = in_valid && !merge_full;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		kda_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.tick      (tick),
			.raw       (raw_pressed[k]),
			.repeat_en (rep_en_q[k]),
			.cfg       (lane_cfg),
			.event_hit (lane_events[k])
		);
	end

	kda_merge #(
		.NUM_KEYS (NUM_KEYS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.lane_events (lane_events),
		.full        (merge_full),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.key_events  (key_events)
	);

endmodule

@@ bench/tb_key_debounce_autorepeat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_autorepeat
// Checks the key debounce / auto-repeat block against a cycle-free predictor
// of its per-key counters: a directed table of scan ticks and register writes
// first, then phases of bouncy presses or plain noise, mostly under random
// settings, random gaps and stalls on both channels, and a forced hold-off.
// ----------------------------------------------------------------------------
module tb_key_debounce_autorepeat;
	import kda_pkg::*;

	localparam int NK              = NUM_KEYS_DEF;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int IDLE_LIMIT      = 4000;
	localparam int DIR_ROWS        = 28;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CNT_W-1:0]     val;
		logic [NK-1:0]        raw;
		bit                   fixed;
		logic [NK-1:0]        events;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [NK-1:0]         raw_pressed;
	logic                  out_valid;
	logic                  out_stall;
	logic [NK-1:0]         key_events;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// predictor copy of settings and per-key state
	logic [CNT_W-1:0] lim_debounce;
	logic [CNT_W-1:0] lim_start;
	logic [CNT_W-1:0] lim_step;
	logic [NK-1:0]    rep_mask;
	logic [NK-1:0]    stable_lv;
	logic [CNT_W-1:0] deb_cnt [NK];
	logic [CNT_W-1:0] hold_cnt [NK];

	logic [NK-1:0] events_due [$];
	int            err_count    = 0;
	bit            quiet        = 1'b0;
	int            hold_off_req = 0;

	// after reset, zero limits, a disabled mask, lowered limits, then extremes
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd0, 1'b1, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b1, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b1, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b1, 3'd7},
		'{ROW_WRITE, REG_DEBOUNCE,     8'd0,   3'd0, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd0, 1'b1, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd5, 1'b1, 3'd5},
		'{ROW_WRITE, REG_REPEAT_START, 8'd0,   3'd0, 1'b0, 3'd0},
		'{ROW_WRITE, REG_REPEAT_STEP,  8'd255, 3'd0, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd5, 1'b1, 3'd4},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b1, 3'd6},
		'{ROW_WRITE, REG_REPEAT_EN,    8'd0,   3'd0, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b1, 3'd0},
		'{ROW_WRITE, REG_REPEAT_EN,    8'd7,   3'd0, 1'b0, 3'd0},
		'{ROW_WRITE, REG_REPEAT_START, 8'd2,   3'd0, 1'b0, 3'd0},
		'{ROW_WRITE, REG_REPEAT_STEP,  8'd1,   3'd0, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b0, 3'd0},
		'{ROW_WRITE, REG_REPEAT_START, 8'd255, 3'd0, 1'b0, 3'd0},
		'{ROW_WRITE, REG_REPEAT_STEP,  8'd255, 3'd0, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b0, 3'd0},
		'{ROW_WRITE, REG_REPEAT_START, 8'd1,   3'd0, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd7, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd2, 1'b0, 3'd0},
		'{ROW_WRITE, REG_DEBOUNCE,     8'd255, 3'd0, 1'b0, 3'd0},
		'{ROW_TICK,  REG_DEBOUNCE,     8'd0,   3'd0, 1'b0, 3'd0}
	};

	key_debounce_autorepeat #(
		.NUM_KEYS(NK)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_pressed(raw_pressed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_events(key_events),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one scan tick through the debounce and hold counters of every key
	function automatic logic [NK-1:0] scan_keys(input logic [NK-1:0] raw);
		logic [NK-1:0] ev;
		ev = '0;
		for (int k = 0; k < NK; k++) begin
			if (raw[k] == stable_lv[k]) begin
				deb_cnt[k] = '0;
			end else begin
				if (deb_cnt[k] != {CNT_W{1'b1}})
					deb_cnt[k] = deb_cnt[k] + 1'b1;
				if (deb_cnt[k] >= lim_debounce) begin
					deb_cnt[k]   = '0;
					hold_cnt[k]  = '0;
					stable_lv[k] = raw[k];
					if (raw[k])
						ev[k] = 1'b1;
				end
			end
			if (rep_mask[k] && stable_lv[k]) begin
				if (hold_cnt[k] != {CNT_W{1'b1}})
					hold_cnt[k] = hold_cnt[k] + 1'b1;
				if (hold_cnt[k] >= lim_start) begin
					ev[k]       = 1'b1;
					hold_cnt[k] = (lim_start > lim_step) ? lim_start - lim_step : '0;
				end
			end
		end
		return ev;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic note_fail(input string what, input logic [NK-1:0] exp_ev,
			input logic [NK-1:0] got_ev);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s: expected key_events %b, got %b", $realtime, what, exp_ev,
				got_ev);
	endtask

	task automatic send_tick(input logic [NK-1:0] raw, input bit fixed,
			input logic [NK-1:0] fixed_ev);
		logic [NK-1:0] ev;
		int            gap;
		@(negedge clk);
		in_valid    = 1'b1;
		raw_pressed = raw;
		do @(posedge clk); while (in_stall);
		ev = scan_keys(raw);
		events_due.push_back(fixed ? fixed_ev : ev);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop offering ticks and let every event mask come back
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (events_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = val;
		case (idx)
			REG_DEBOUNCE:     lim_debounce = val;
			REG_REPEAT_START: lim_start    = val;
			REG_REPEAT_STEP:  lim_step     = val;
			REG_REPEAT_EN:    rep_mask     = val[NK-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// keys held for random runs with contact bounce, or plain noise
	task automatic run_phase(input int n_ticks, input int max_run, input bit noisy,
			input bit pause_mid);
		logic [NK-1:0] intent;
		logic [NK-1:0] raw;
		int            run_left [NK];
		intent = stable_lv;
		for (int k = 0; k < NK; k++)
			run_left[k] = $urandom_range(0, max_run);
		for (int t = 0; t < n_ticks; t++) begin
			if (pause_mid && t == n_ticks / 2)
				settle();
			if (noisy) begin
				raw = NK'($urandom);
			end else begin
				for (int k = 0; k < NK; k++) begin
					if (run_left[k] == 0) begin
						intent[k]   = ~intent[k];
						run_left[k] = $urandom_range(1, max_run);
					end else begin
						run_left[k]--;
					end
				end
				raw = intent;
				if ($urandom_range(0, 7) == 0)
					raw[$urandom_range(0, NK - 1)] ^= 1'b1;
			end
			send_tick(raw, 1'b0, '0);
		end
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int stall_left;
		int hold_off_done;
		stall_left    = 0;
		hold_off_done = 0;
		out_stall     = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req != hold_off_done) begin
				stall_left    = HOLD_OFF_CYCLES;
				hold_off_done = hold_off_req;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (pick_gap() > 0) begin
				out_stall  = 1'b1;
				stall_left = pick_gap();
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		logic [NK-1:0] exp_ev;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (events_due.size() == 0) begin
					note_fail("event mask with no scan tick pending", '0, key_events);
				end else begin
					exp_ev = events_due.pop_front();
					if (exp_ev !== key_events)
						note_fail("key_events mismatch", exp_ev, key_events);
				end
			end
		end
	end

	// ends the run when no transaction moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int n_ticks;
		int max_run;
		in_valid     = 1'b0;
		raw_pressed  = '0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_DEBOUNCE;
		cfg_wdata    = '0;
		arst_n       = 1'b0;
		lim_debounce = DEBOUNCE_RST;
		lim_start    = REPEAT_START_RST;
		lim_step     = REPEAT_STEP_RST;
		rep_mask     = NK'(REPEAT_EN_RST);
		stable_lv    = '0;
		for (int k = 0; k < NK; k++) begin
			deb_cnt[k]  = '0;
			hold_cnt[k] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_tick(dir_rows[i].raw, dir_rows[i].fixed, dir_rows[i].events);
			end
		end
		settle();

		for (int p = 0; p < 12; p++) begin
			n_ticks = 100;
			case (p)
				0: begin
					write_reg(REG_DEBOUNCE, 8'd0);
					write_reg(REG_REPEAT_START, 8'd1);
					write_reg(REG_REPEAT_STEP, 8'd1);
					write_reg(REG_REPEAT_EN, 8'hFF);
					max_run = 8;
				end
				1: begin
					// slowest settings, long holds so a few flips and repeats happen
					write_reg(REG_DEBOUNCE, 8'd255);
					write_reg(REG_REPEAT_START, 8'd255);
					write_reg(REG_REPEAT_STEP, 8'd255);
					write_reg(REG_REPEAT_EN, 8'd7);
					max_run = 320;
					n_ticks = 400;
				end
				default: begin
					write_reg(REG_DEBOUNCE, CFG_DATA_W'($urandom_range(0, 6)));
					write_reg(REG_REPEAT_START, CFG_DATA_W'($urandom_range(0, 24)));
					write_reg(REG_REPEAT_STEP, CFG_DATA_W'($urandom_range(0, 30)));
					write_reg(REG_REPEAT_EN, CFG_DATA_W'($urandom));
					max_run = int'(lim_debounce) + 2 * int'(lim_start) + 6;
				end
			endcase
			// back-to-back ticks against a long receiver hold-off fill the block
			quiet = (p == 3 || p == 9);
			if (p == 3)
				hold_off_req++;
			run_phase(n_ticks, max_run, p == 7, p == 5);
			settle();
		end
		quiet = 1'b0;

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
